// ===== rtl/core/tpm_pkg.sv =====
// Shared types, constants and the sample-to-degree conversion of the thermal protection monitor.
`default_nettype none

package tpm_pkg;

    // Width of one raw sample field and the number of sample bits that count
    localparam int INPUT_BITS  = 12;
    localparam int SAMPLE_BITS = 12;
    localparam logic [INPUT_BITS-1:0] SAMPLE_MASK =
        INPUT_BITS'((33'd1 << SAMPLE_BITS) - 33'd1);

    // Degree and threshold width
    localparam int DEG_BITS = 7;
    localparam logic [DEG_BITS-1:0] DEGREE_CAP = 7'd100;

    // Scaled sample 4*s+25 and the clamp point 50*101
    localparam int SUM_BITS = INPUT_BITS + 3;
    localparam logic [SUM_BITS-1:0] SUM_BIAS  = SUM_BITS'(25);
    localparam logic [SUM_BITS-1:0] SUM_CLAMP = SUM_BITS'(5050);

    // Reciprocal of 50: ceil(2^18 / 50), exact for dividends below 5050
    localparam int QUO_BITS   = 13;
    localparam int RECIP_SHIFT = 18;
    localparam logic [QUO_BITS-1:0] RECIP_50 = 13'd5243;

    // APB register map
    localparam int ADDR_BITS = 4;
    localparam logic [1:0] REG_ERROR_THR = 2'd0;
    localparam logic [1:0] REG_HIGH_THR  = 2'd1;
    localparam logic [1:0] REG_LOW_THR   = 2'd2;

    localparam logic [DEG_BITS-1:0] ERROR_THR_RST = 7'd90;
    localparam logic [DEG_BITS-1:0] HIGH_THR_RST  = 7'd80;
    localparam logic [DEG_BITS-1:0] LOW_THR_RST   = 7'd70;

    // Stream payload widths
    localparam int S_DATA_BITS = 40;
    localparam int M_DATA_BITS = 48;

    typedef enum logic [1:0] {
        LVL_SAFE  = 2'd0,
        LVL_WARN1 = 2'd1,
        LVL_WARN2 = 2'd2,
        LVL_ERROR = 2'd3
    } level_t;

    typedef struct packed {
        logic [DEG_BITS-1:0] error_thr;
        logic [DEG_BITS-1:0] high_thr;
        logic [DEG_BITS-1:0] low_thr;
    } thresholds_t;

    // Classified item carried from the front part to the back part
    typedef struct packed {
        level_t              level;
        logic [DEG_BITS-1:0] deg0;
        logic [DEG_BITS-1:0] deg1;
        logic [DEG_BITS-1:0] deg2;
        logic [DEG_BITS-1:0] hottest;
    } entry_t;

    // Result item held in the output register
    typedef struct packed {
        level_t              level;
        logic [31:0]         packed_degrees;
        logic [DEG_BITS-1:0] hottest;
        logic                muted;
        logic                power_cut;
        logic                led_write;
        logic [1:0]          led_code;
    } result_t;

    // Round-half-up of sample / 12.5, clamped to 100
    function automatic logic [DEG_BITS-1:0] to_degree(input logic [INPUT_BITS-1:0] raw);
        logic [INPUT_BITS-1:0]      s;
        logic [SUM_BITS-1:0]        x;
        logic [2*QUO_BITS-1:0]      prod;
        logic [DEG_BITS-1:0]        q;
        s    = raw & SAMPLE_MASK;
        x    = {s, 2'b00} + SUM_BIAS;
        prod = {{QUO_BITS{1'b0}}, x[QUO_BITS-1:0]} * {{QUO_BITS{1'b0}}, RECIP_50};
        q    = prod[RECIP_SHIFT +: DEG_BITS];
        if (x >= SUM_CLAMP)
        begin
            q = DEGREE_CAP;
        end
        else if (q > DEGREE_CAP)
        begin
            q = DEGREE_CAP;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tpm_front.sv =====
// Front part: accepts sample sets, converts them to degrees and classifies the hottest one.
`default_nettype none

module tpm_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata: first_sample[11:0], second_sample[23:12], third_sample[35:24], zero pad
    input  wire logic [tpm_pkg::S_DATA_BITS-1:0] s_tdata,
    input  wire tpm_pkg::thresholds_t          thr,
    input  wire logic                          q_full,
    output logic                               push,
    output tpm_pkg::entry_t                    push_entry
);

    logic                          stage_valid_reg;
    logic                          stage_valid_next;
    logic [tpm_pkg::DEG_BITS-1:0]  deg0_reg;
    logic [tpm_pkg::DEG_BITS-1:0]  deg1_reg;
    logic [tpm_pkg::DEG_BITS-1:0]  deg2_reg;
    logic [tpm_pkg::DEG_BITS-1:0]  hot01;
    logic [tpm_pkg::DEG_BITS-1:0]  hottest;
    tpm_pkg::level_t               level;
    logic                          take;

    // Accept when the stage is empty or moves on this cycle
    assign s_tready = !stage_valid_reg || !q_full;
    assign take     = s_tvalid && s_tready;
    assign push     = stage_valid_reg && !q_full;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    // Hold the stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Register the converted degrees of each channel
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            deg0_reg <= tpm_pkg::to_degree(s_tdata[11:0]);
            deg1_reg <= tpm_pkg::to_degree(s_tdata[23:12]);
            deg2_reg <= tpm_pkg::to_degree(s_tdata[35:24]);
        end
    end

    // Find the hottest channel and classify it from error down to warn1, else safe
    always_comb
    begin
        hot01   = (deg1_reg > deg0_reg) ? deg1_reg : deg0_reg;
        hottest = (deg2_reg > hot01) ? deg2_reg : hot01;
        if (hottest > thr.error_thr)
        begin
            level = tpm_pkg::LVL_ERROR;
        end
        else if (hottest > thr.high_thr)
        begin
            level = tpm_pkg::LVL_WARN2;
        end
        else if (hottest > thr.low_thr)
        begin
            level = tpm_pkg::LVL_WARN1;
        end
        else
        begin
            level = tpm_pkg::LVL_SAFE;
        end
    end

    assign push_entry.level   = level;
    assign push_entry.deg0    = deg0_reg;
    assign push_entry.deg1    = deg1_reg;
    assign push_entry.deg2    = deg2_reg;
    assign push_entry.hottest = hottest;

endmodule

`default_nettype wire

// ===== rtl/core/tpm_queue.sv =====
// Two-entry queue between the classifying front part and the protection back part.
`default_nettype none

module tpm_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tpm_pkg::entry_t push_entry,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output tpm_pkg::entry_t      pop_entry
);

    tpm_pkg::entry_t entries_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_entry = entries_reg[rd_ptr_reg];

    // Advance pointers and the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tpm_back.sv =====
// Back part: applies the error latch, mute and power-cut rules and holds the result register.
`default_nettype none

module tpm_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_not_empty,
    input  wire tpm_pkg::entry_t q_entry,
    output logic                 pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output tpm_pkg::result_t     result
);

    tpm_pkg::level_t  last_level_reg;
    tpm_pkg::level_t  last_level_next;
    logic             mute_reg;
    logic             mute_next;
    logic             cut_reg;
    logic             cut_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    tpm_pkg::result_t result_reg;
    tpm_pkg::result_t result_next;
    logic             led_write;
    logic [1:0]       led_code;

    assign pop      = q_not_empty && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign result   = result_reg;

    // Protection rules for the popped level
    always_comb
    begin
        last_level_next = last_level_reg;
        mute_next       = mute_reg;
        cut_next        = cut_reg;
        led_write       = 1'b0;
        led_code        = 2'd0;
        if (last_level_reg == tpm_pkg::LVL_ERROR)
        begin
            // Latched until the level drops to warn1 or safe
            if (q_entry.level <= tpm_pkg::LVL_WARN1)
            begin
                cut_next        = 1'b0;
                mute_next       = 1'b0;
                led_write       = 1'b1;
                led_code        = q_entry.level;
                last_level_next = q_entry.level;
            end
        end
        else
        begin
            if (q_entry.level != last_level_reg)
            begin
                led_write = 1'b1;
                led_code  = q_entry.level;
                case (q_entry.level)
                    tpm_pkg::LVL_SAFE, tpm_pkg::LVL_WARN1:
                    begin
                        if (last_level_reg > tpm_pkg::LVL_WARN1)
                        begin
                            mute_next = 1'b0;
                        end
                    end
                    tpm_pkg::LVL_WARN2:
                    begin
                        mute_next = 1'b1;
                    end
                    default:
                    begin
                        mute_next = 1'b1;
                        cut_next  = 1'b1;
                    end
                endcase
            end
            last_level_next = q_entry.level;
        end
    end

    // Build the next result and output valid
    always_comb
    begin
        result_next                = result_reg;
        out_valid_next             = out_valid_reg;
        if (pop)
        begin
            result_next.level          = q_entry.level;
            result_next.packed_degrees = {1'b0, q_entry.deg0, 1'b0, q_entry.deg1,
                                          1'b0, q_entry.deg2, 8'd0};
            result_next.hottest        = q_entry.hottest;
            result_next.muted          = mute_next;
            result_next.power_cut      = cut_next;
            result_next.led_write      = led_write;
            result_next.led_code       = led_code;
            out_valid_next             = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold protection state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= tpm_pkg::LVL_SAFE;
            mute_reg       <= 1'b0;
            cut_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                last_level_reg <= last_level_next;
                mute_reg       <= mute_next;
                cut_reg        <= cut_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Power is cut exactly while the error latch is held
    assert property (@(posedge clk) disable iff (!rst_n)
        cut_reg == (last_level_reg == tpm_pkg::LVL_ERROR))
    else $error("power cut out of step with error latch");

    // A cut always comes with mute
    assert property (@(posedge clk) disable iff (!rst_n)
        cut_reg |-> mute_reg)
    else $error("power cut without mute");

    // An issued LED code names the reported level, otherwise it is none
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.led_write ? (result_reg.led_code == result_reg.level)
                                                : (result_reg.led_code == 2'd0)))
    else $error("LED code does not match level");

endmodule

`default_nettype wire

// ===== rtl/core/thermal_protection_monitor.sv =====
// Top level of the thermal protection monitor: APB thresholds, front, queue and back parts.
// Path: each input transfer passes the degree stage, the queue and the output register
// before its result is offered on m_tvalid.
// Throughput: one sample set per cycle unless m_tready stalls the output and the queue
// fills; the degree stage holds three reciprocal multipliers.
// Reset (rst_n low, asynchronous): thresholds return to 90/80/70, level to safe,
// unmuted, power on, queue and output register empty.
`default_nettype none

module thermal_protection_monitor
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tpm_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata: first_sample[11:0], second_sample[23:12], third_sample[35:24], zero pad
    input  wire logic [tpm_pkg::S_DATA_BITS-1:0] s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: level[1:0], packed_degrees[33:2], hottest_degree[40:34], muted[41],
    // power_cut[42], led_write[43], led_code[45:44], zero pad
    output logic [tpm_pkg::M_DATA_BITS-1:0]      m_tdata
);

    tpm_pkg::thresholds_t thr_reg;
    tpm_pkg::thresholds_t thr_next;
    logic                 cfg_write;
    logic                 q_full;
    logic                 push;
    tpm_pkg::entry_t      push_entry;
    logic                 pop;
    logic                 q_not_empty;
    tpm_pkg::entry_t      q_entry;
    tpm_pkg::result_t     result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Decode threshold writes
    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_write)
        begin
            case (paddr[3:2])
                tpm_pkg::REG_ERROR_THR: thr_next.error_thr = pwdata[tpm_pkg::DEG_BITS-1:0];
                tpm_pkg::REG_HIGH_THR:  thr_next.high_thr  = pwdata[tpm_pkg::DEG_BITS-1:0];
                tpm_pkg::REG_LOW_THR:   thr_next.low_thr   = pwdata[tpm_pkg::DEG_BITS-1:0];
                default:                thr_next = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.error_thr <= tpm_pkg::ERROR_THR_RST;
            thr_reg.high_thr  <= tpm_pkg::HIGH_THR_RST;
            thr_reg.low_thr   <= tpm_pkg::LOW_THR_RST;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    // Read back thresholds
    always_comb
    begin
        case (paddr[3:2])
            tpm_pkg::REG_ERROR_THR: prdata = {25'd0, thr_reg.error_thr};
            tpm_pkg::REG_HIGH_THR:  prdata = {25'd0, thr_reg.high_thr};
            tpm_pkg::REG_LOW_THR:   prdata = {25'd0, thr_reg.low_thr};
            default:                prdata = 32'd0;
        endcase
    end

    tpm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .thr        (thr_reg),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    tpm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .pop_entry  (q_entry)
    );

    tpm_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_entry     (q_entry),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .result      (result)
    );

    // Pack the result fields, with the level in the lowest bits
    assign m_tdata = {2'b00, result.led_code, result.led_write, result.power_cut,
                      result.muted, result.hottest, result.packed_degrees, result.level};

endmodule

`default_nettype wire

// ===== tb/tpm_result_checker.sv =====
// Checker for the thermal protection monitor: tracks thresholds, predicts and compares results.
`timescale 1ns / 100ps

module tpm_result_checker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tpm_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [31:0]                     pwdata,
    input  wire logic                            pready,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    // s_tdata: first_sample[11:0], second_sample[23:12], third_sample[35:24], zero pad
    input  wire logic [tpm_pkg::S_DATA_BITS-1:0] s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: level[1:0], packed_degrees[33:2], hottest_degree[40:34], muted[41],
    // power_cut[42], led_write[43], led_code[45:44], zero pad
    input  wire logic [tpm_pkg::M_DATA_BITS-1:0] m_tdata,
    output int                                   pending,
    output int                                   checked,
    output int                                   errors
);

    typedef struct packed {
        tpm_pkg::level_t level;
        logic [31:0]     degrees;
        logic [6:0]      hottest;
        logic            muted;
        logic            power_cut;
        logic            led_write;
        logic [1:0]      led_code;
    } reading_t;

    // Thresholds as last written over APB
    logic [6:0] err_thr  = 7'd90;
    logic [6:0] high_thr = 7'd80;
    logic [6:0] low_thr  = 7'd70;

    // Protection state of the predictor
    tpm_pkg::level_t prev_level = tpm_pkg::LVL_SAFE;
    logic            mute_on    = 1'b0;
    logic            power_off  = 1'b0;

    reading_t expected_readings[$];
    int       mismatches = 0;
    int       results_seen = 0;

    // Round half up of sample / 12.5, clamped at 100 degrees
    function automatic logic [6:0] degree_of(input logic [11:0] raw);
        int unsigned d;
        d = (4 * int'(raw) + 25) / 50;
        if (d > 100)
        begin
            d = 100;
        end
        return 7'(d);
    endfunction

    // Classify the hottest channel and advance the mute and power-cut latches
    function automatic reading_t predict_reading(input logic [tpm_pkg::S_DATA_BITS-1:0] data);
        reading_t        r;
        logic [6:0]      deg;
        tpm_pkg::level_t lvl;
        r = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            deg = degree_of(data[12*ch +: 12]);
            r.degrees[31 - 8*ch -: 8] = {1'b0, deg};
            if (deg > r.hottest)
            begin
                r.hottest = deg;
            end
        end

        if (r.hottest > err_thr)
        begin
            lvl = tpm_pkg::LVL_ERROR;
        end
        else if (r.hottest > high_thr)
        begin
            lvl = tpm_pkg::LVL_WARN2;
        end
        else if (r.hottest > low_thr)
        begin
            lvl = tpm_pkg::LVL_WARN1;
        end
        else
        begin
            lvl = tpm_pkg::LVL_SAFE;
        end

        if (prev_level == tpm_pkg::LVL_ERROR)
        begin
            // Error stays latched until the level drops to warn1 or safe
            if (lvl == tpm_pkg::LVL_SAFE || lvl == tpm_pkg::LVL_WARN1)
            begin
                power_off   = 1'b0;
                mute_on     = 1'b0;
                r.led_write = 1'b1;
                r.led_code  = lvl;
                prev_level  = lvl;
            end
        end
        else
        begin
            if (lvl != prev_level)
            begin
                r.led_write = 1'b1;
                r.led_code  = lvl;
                case (lvl)
                    tpm_pkg::LVL_SAFE, tpm_pkg::LVL_WARN1:
                    begin
                        if (prev_level == tpm_pkg::LVL_WARN2)
                        begin
                            mute_on = 1'b0;
                        end
                    end
                    tpm_pkg::LVL_WARN2:
                    begin
                        mute_on = 1'b1;
                    end
                    default:
                    begin
                        mute_on   = 1'b1;
                        power_off = 1'b1;
                    end
                endcase
            end
            prev_level = lvl;
        end

        r.level     = lvl;
        r.muted     = mute_on;
        r.power_cut = power_off;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            err_thr    = 7'd90;
            high_thr   = 7'd80;
            low_thr    = 7'd70;
            prev_level = tpm_pkg::LVL_SAFE;
            mute_on    = 1'b0;
            power_off  = 1'b0;
            expected_readings.delete();
        end
        else
        begin
            // Track threshold writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    tpm_pkg::REG_ERROR_THR: err_thr  = pwdata[6:0];
                    tpm_pkg::REG_HIGH_THR:  high_thr = pwdata[6:0];
                    tpm_pkg::REG_LOW_THR:   low_thr  = pwdata[6:0];
                    default: ;
                endcase
            end

            // Predict on every accepted sample set
            if (s_tvalid && s_tready)
            begin
                expected_readings.push_back(predict_reading(s_tdata));
            end

            // Compare every accepted result with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_readings.size() == 0)
                begin
                    $error("result with no expectation waiting: 0x%0h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    check_field("level", 32'(want.level), 32'(m_tdata[1:0]));
                    check_field("packed_degrees", want.degrees, m_tdata[33:2]);
                    check_field("hottest_degree", 32'(want.hottest), 32'(m_tdata[40:34]));
                    check_field("muted", 32'(want.muted), 32'(m_tdata[41]));
                    check_field("power_cut", 32'(want.power_cut), 32'(m_tdata[42]));
                    check_field("led_write", 32'(want.led_write), 32'(m_tdata[43]));
                    check_field("led_code", 32'(want.led_code), 32'(m_tdata[45:44]));
                end
            end
        end
        pending <= expected_readings.size();
        checked <= results_seen;
        errors  <= mismatches;
    end

endmodule

// ===== tb/thermal_protection_monitor_tb.sv =====
// Testbench top for the thermal protection monitor: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module thermal_protection_monitor_tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [tpm_pkg::ADDR_BITS-1:0]   paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;
    logic                            s_tvalid;
    logic                            s_tready;
    // s_tdata: first_sample[11:0], second_sample[23:12], third_sample[35:24], zero pad
    logic [tpm_pkg::S_DATA_BITS-1:0] s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    // m_tdata: level[1:0], packed_degrees[33:2], hottest_degree[40:34], muted[41],
    // power_cut[42], led_write[43], led_code[45:44], zero pad
    logic [tpm_pkg::M_DATA_BITS-1:0] m_tdata;

    int pending;
    int checked;
    int errors;
    int cycle_count = 0;
    int sets_sent = 0;
    int settings_used = 1;
    int thr_now[3] = '{90, 80, 70};
    bit calm = 1'b0;

    thermal_protection_monitor u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tpm_result_checker u_check
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .pending  (pending),
        .checked  (checked),
        .errors   (errors)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stall the result side in random bursts; hold ready high once calm
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (calm || $urandom_range(0, 2) != 0)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    end

    // Random raw sample that converts to the given degree
    function automatic logic [11:0] sample_for_degree(input int deg);
        int lo;
        int hi;
        if (deg >= 100)
        begin
            return 12'($urandom_range(4095, 1244));
        end
        lo = (deg == 0) ? 0 : (50 * deg - 22) / 4;
        hi = (50 * deg + 24) / 4;
        return 12'($urandom_range(hi, lo));
    endfunction

    // Offer one sample set and hold it until the transfer, then maybe idle
    task automatic send_samples(input logic [11:0] a, input logic [11:0] b,
                                input logic [11:0] c);
        s_tdata  <= {4'b0000, c, b, a};
        s_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sets_sent++;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic send_degrees(input int d0, input int d1, input int d2);
        send_samples(sample_for_degree(d0), sample_for_degree(d1), sample_for_degree(d2));
    endtask

    // Drop valid and hold off until every expected result has transferred
    task automatic drain();
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access until pready
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly sets whose hottest channel sits near a threshold, some full-range noise
    task automatic random_item();
        logic [11:0] s[3];
        int          pick;
        int          deg;
        int          hot;
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                s[ch] = 12'($urandom_range(4095, 0));
            end
        end
        else
        begin
            deg = thr_now[$urandom_range(2, 0)] - 2 + int'($urandom_range(4, 0));
            if (pick == 2)
            begin
                deg = $urandom_range(100, 0);
            end
            if (deg < 0)
            begin
                deg = 0;
            end
            if (deg > 100)
            begin
                deg = 100;
            end
            hot = $urandom_range(2, 0);
            for (int ch = 0; ch < 3; ch++)
            begin
                s[ch] = (ch == hot) ? sample_for_degree(deg)
                                    : sample_for_degree($urandom_range(deg, 0));
            end
        end
        send_samples(s[0], s[1], s[2]);
    endtask

    // Reprogram all thresholds while idle, then run random sample sets
    task automatic run_phase(input int err_deg, input int high_deg, input int low_deg,
                             input int count);
        drain();
        write_reg(tpm_pkg::REG_ERROR_THR, err_deg);
        write_reg(tpm_pkg::REG_HIGH_THR, high_deg);
        write_reg(tpm_pkg::REG_LOW_THR, low_deg);
        thr_now = '{err_deg, high_deg, low_deg};
        settings_used++;
        repeat (count) random_item();
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk through the levels at the reset thresholds
        send_samples(12'h000, 12'h000, 12'h000);
        send_degrees(71, 0, 0);
        send_degrees(71, 0, 0);
        send_degrees(0, 81, 0);
        send_degrees(0, 0, 91);
        // Error latched: warn2 and error change nothing
        send_degrees(85, 0, 0);
        send_samples(12'hFFF, 12'hFFF, 12'hFFF);
        // Recovery to warn1 restores power and unmutes
        send_degrees(75, 0, 0);
        send_degrees(90, 90, 90);
        // Warn2 straight to safe unmutes
        send_degrees(0, 0, 0);
        send_samples(12'd0, 12'd1244, 12'd0);
        send_degrees(0, 0, 0);
        send_degrees(70, 70, 70);
        send_degrees(0, 80, 0);
        send_samples(12'hAAA, 12'h555, 12'hAAA);
        send_samples(12'h555, 12'hAAA, 12'h555);
        send_degrees(0, 0, 91);
        send_degrees(80, 0, 0);
        send_degrees(0, 0, 81);
        send_degrees(75, 0, 0);
        send_samples(12'hFFF, 12'h000, 12'h7FF);
        send_samples(12'h001, 12'h800, 12'h006);

        // Threshold settings, extremes and out-of-order ones among them
        run_phase(100, 100, 100, 50);
        run_phase(0, 0, 0, 50);
        run_phase(50, 60, 70, 55);
        drain();
        write_reg(REG_UNUSED, 32'h15);
        run_phase(100, 50, 0, 55);
        run_phase(60, 40, 20, 55);
        run_phase($urandom_range(100, 0), $urandom_range(100, 0), $urandom_range(100, 0), 55);
        run_phase($urandom_range(100, 0), $urandom_range(100, 0), $urandom_range(100, 0), 55);
        run_phase(1, 99, 50, 40);

        // Final part at the reset thresholds without idling on either side
        calm = 1'b1;
        run_phase(90, 80, 70, 60);
        drain();
        repeat (8) @(posedge clk);

        $display("Run covered %0d sample sets under %0d threshold settings; %0d results checked.",
                 sets_sent, settings_used, checked);
        $display("Included: error latch and recovery, unmute paths, clamping, unused register.");
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/tpm_pkg.sv
rtl/core/tpm_front.sv
rtl/core/tpm_queue.sv
rtl/core/tpm_back.sv
rtl/core/thermal_protection_monitor.sv
tb/tpm_result_checker.sv
tb/thermal_protection_monitor_tb.sv
